@@ sv/pgr_pkg.sv @@
// pgr_pkg: shared constants, codes and helpers of the pairwise relatedness block
// no dependencies; imported by every module of the block except pgr_ram
package pgr_pkg;

   localparam int MaxSamples = 4096;
   localparam int MaxPairs   = 64;
   localparam int RowDepth   = (MaxSamples + 3) / 4;

   localparam int SampleW  = 12;
   localparam int SlotW    = 6;
   localparam int SlotCntW = 7;
   localparam int RowAddrW = 10;
   localparam int WeightW  = 27;
   localparam int SumW     = 64;
   localparam int CountW   = 24;
   localparam int ResW     = 24;
   localparam int AccW     = SumW + CountW;
   localparam int MemberW  = 2 * SampleW;
   localparam int RadW     = 48;
   localparam int RootW    = 24;
   localparam int DivW     = 64;
   localparam int DvsW     = 40;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_START = 2'd1,
      KIND_BYTE  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   localparam logic REG_SAMPLE_COUNT = 1'b0;
   localparam logic REG_PAIR_COUNT   = 1'b1;

   localparam logic [1:0] GENO_TWO  = 2'b00;
   localparam logic [1:0] GENO_MISS = 2'b01;
   localparam logic [1:0] GENO_ONE  = 2'b10;
   localparam logic [1:0] GENO_NONE = 2'b11;

   // allele count 0..2, or 3 for a missing call
   localparam logic [1:0] ALLELE_MISSING = 2'd3;

   function automatic logic [1:0] geno_decode(input logic [7:0] row_byte,
                                              input logic [1:0] lane);
      logic [1:0] code;
      logic [1:0] cnt;
      unique case (lane)
         2'd0: code = row_byte[1:0];
         2'd1: code = row_byte[3:2];
         2'd2: code = row_byte[5:4];
         default: code = row_byte[7:6];
      endcase
      unique case (code)
         GENO_TWO:  cnt = 2'd2;
         GENO_ONE:  cnt = 2'd1;
         GENO_NONE: cnt = 2'd0;
         default:   cnt = ALLELE_MISSING;
      endcase
      return cnt;
   endfunction

endpackage

@@ sv/pairwise_genomic_relatedness.sv @@
// pairwise_genomic_relatedness: top level, sequencer around pair, sum and row memories
// depends on pgr_pkg, pgr_ram, pgr_sqrt, pgr_div
//
// usage: the req channel carries one transaction per item, selected by req_kind:
//   load pair   - stores the pair (smaller sample first) and clears its sums
//   marker start- skip check, then a square root and three divisions
//                 for the weights of allele counts 0, 1 and 2
//   genotype byte - stored; the last byte of a row starts a pair walk through the
//                 states pair, lo, hi, mul and acc per active pair (one row ram read port)
//   read pair   - fetches the slot and divides the sum by count<<16 in the shared
//                 divider; the result goes to rsp, skipping the division if count is 0
// one transaction is worked on at a time: req_ready is high only while idle.
// a finished result waits in the rsp output register; further loads, markers and
// bytes are taken while it waits, a following read holds until rsp is taken.
// configuration (sample_count at 0x0, pair_count at 0x4) must be written over csr_ only
// while idle; the block does not enforce it. reset (synchronous, active high) clears
// control state, weights, skip flag, byte position and per-slot valid bits of the sums.
module pairwise_genomic_relatedness
   import pgr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [SlotW-1:0]         req_pair_index,
   input  logic [SampleW-1:0]       req_first_sample,
   input  logic [SampleW-1:0]       req_second_sample,
   input  logic [16:0]              req_allele_freq,
   input  logic [7:0]               req_geno_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [SlotW-1:0]         rsp_pair_index_res,
   output logic [CountW-1:0]        rsp_marker_count,
   output logic signed [ResW-1:0]   rsp_relatedness,
   output logic                     rsp_defined,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQRT,
      S_WLAUNCH,
      S_WDIV,
      S_PAIR,
      S_LO,
      S_HI,
      S_MUL,
      S_ACC,
      S_RD_WAIT,
      S_RD_DIV,
      S_RD_SAT,
      S_RD_OUT
   } state_type;

   state_type state_ff;

   logic [12:0]               sample_count_ff;
   logic [SlotCntW-1:0]       pair_count_ff;
   logic [RowAddrW-1:0]       byte_pos_ff;
   logic                      skip_ff;
   logic signed [WeightW-1:0] w_ff [3];
   logic [15:0]               freq_ff;
   logic [RootW-1:0]          denom_ff;
   logic [1:0]                wx_ff;
   logic [SlotCntW-1:0]       k_ff;
   logic [SampleW-1:0]        lo_ff;
   logic [SampleW-1:0]        hi_ff;
   logic [1:0]                ca_ff;
   logic signed [53:0]        prod_ff;
   logic                      pvalid_ff;
   logic [MaxPairs-1:0]       acc_valid_ff;
   logic                      acc_vld_ff;
   logic [SlotW-1:0]          slot_ff;
   logic [CountW-1:0]         cnt_ff;
   logic                      neg_ff;
   logic [DivW-1:0]           qr_ff;
   logic signed [ResW-1:0]    rel_ff;
   logic                      rsp_valid_ff;
   logic [SlotW-1:0]          rsp_slot_ff;
   logic [CountW-1:0]         rsp_count_ff;
   logic signed [ResW-1:0]    rsp_rel_ff;
   logic                      rsp_def_ff;

   // effective configuration
   logic [12:0]               n_eff;
   logic [10:0]               row_len;
   logic [SlotCntW-1:0]       pc_eff;

   logic                      req_fire;
   logic                      csr_write;
   logic [10:0]               pos_next;
   logic                      row_end;
   logic                      rsp_load;

   // memories
   logic                      pr_wr_en;
   logic [MemberW-1:0]        pr_wr_data;
   logic                      pr_rd_en;
   logic [MemberW-1:0]        pr_rd_data;
   logic                      acc_wr_en;
   logic [SlotW-1:0]          acc_wr_addr;
   logic [AccW-1:0]           acc_wr_data;
   logic                      acc_rd_en;
   logic [SlotW-1:0]          acc_rd_addr;
   logic [AccW-1:0]           acc_rd_data;
   logic                      row_wr_en;
   logic                      row_rd_en;
   logic [RowAddrW-1:0]       row_rd_addr;
   logic [7:0]                row_rd_data;

   logic [CountW-1:0]         acc_cnt;
   logic signed [SumW-1:0]    acc_sum;

   // arithmetic units
   logic                      sqrt_start;
   logic [RadW-1:0]           radicand;
   logic                      sqrt_done;
   logic [RootW-1:0]          sqrt_root;
   logic                      div_start;
   logic [DivW-1:0]           div_dividend;
   logic [DvsW-1:0]           div_divisor;
   logic                      div_done;
   logic [DivW-1:0]           div_quot;
   logic [DvsW-1:0]           div_rem;

   logic [33:0]               freq_prod;
   logic signed [17:0]        wnum;
   logic [16:0]               wmag;
   logic [SumW-1:0]           sum_mag;
   logic [DvsW-1:0]           rd_divisor;
   logic [1:0]                cb;
   logic                      miss_lo;
   logic                      miss_hi;
   logic signed [WeightW-1:0] wa;
   logic signed [WeightW-1:0] wb;
   logic signed [SumW-1:0]    prod_ext;
   logic signed [SumW-1:0]    sum_new;
   logic signed [SumW-1:0]    sum_sat;
   logic [CountW-1:0]         cnt_new;

   assign n_eff = (sample_count_ff == 13'd0) ? 13'd1 :
                  (sample_count_ff > 13'(MaxSamples)) ? 13'(MaxSamples) : sample_count_ff;
   assign row_len = 11'((14'(n_eff) + 14'd3) >> 2);
   assign pc_eff = (pair_count_ff > SlotCntW'(MaxPairs)) ? SlotCntW'(MaxPairs) : pair_count_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign pos_next  = {1'b0, byte_pos_ff} + 11'd1;
   assign row_end   = (pos_next >= row_len);
   assign rsp_load  = (state_ff == S_RD_OUT) && (!rsp_valid_ff || rsp_ready);

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_PAIR_COUNT) ? {25'd0, pair_count_ff} :
                                                          {19'd0, sample_count_ff};

   // memory controls
   assign pr_wr_en   = req_fire && (kind_type'(req_kind) == KIND_LOAD);
   assign pr_wr_data = (req_first_sample < req_second_sample) ?
                       {req_first_sample, req_second_sample} :
                       {req_second_sample, req_first_sample};
   assign pr_rd_en   = (state_ff == S_PAIR);

   assign acc_rd_en   = (state_ff == S_PAIR) ||
                        (req_fire && (kind_type'(req_kind) == KIND_READ));
   assign acc_rd_addr = (state_ff == S_PAIR) ? k_ff[SlotW-1:0] : req_pair_index;
   assign acc_cnt     = acc_vld_ff ? acc_rd_data[AccW-1:SumW] : '0;
   assign acc_sum     = acc_vld_ff ? signed'(acc_rd_data[SumW-1:0]) : '0;

   assign row_wr_en   = req_fire && (kind_type'(req_kind) == KIND_BYTE);
   assign row_rd_en   = (state_ff == S_LO) || (state_ff == S_HI);
   assign row_rd_addr = (state_ff == S_LO) ? pr_rd_data[MemberW-1:SampleW+2]
                                           : hi_ff[SampleW-1:2];

   // walk datapath
   assign miss_lo = ({1'b0, lo_ff} >= n_eff);
   assign miss_hi = ({1'b0, hi_ff} >= n_eff);
   assign cb      = miss_hi ? ALLELE_MISSING : geno_decode(row_rd_data, hi_ff[1:0]);

   always_comb begin
      unique case (ca_ff)
         2'd0:    wa = w_ff[0];
         2'd1:    wa = w_ff[1];
         default: wa = w_ff[2];
      endcase
      unique case (cb)
         2'd0:    wb = w_ff[0];
         2'd1:    wb = w_ff[1];
         default: wb = w_ff[2];
      endcase
   end

   assign prod_ext = SumW'(prod_ff);
   assign sum_new  = acc_sum + prod_ext;
   assign sum_sat  = ((acc_sum[SumW-1] == prod_ext[SumW-1]) &&
                      (sum_new[SumW-1] != acc_sum[SumW-1])) ?
                     (acc_sum[SumW-1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}})
                     : sum_new;
   assign cnt_new  = (acc_cnt == {CountW{1'b1}}) ? acc_cnt : acc_cnt + CountW'(1);

   assign acc_wr_en   = pr_wr_en || ((state_ff == S_ACC) && pvalid_ff);
   assign acc_wr_addr = (state_ff == S_ACC) ? k_ff[SlotW-1:0] : req_pair_index;
   assign acc_wr_data = (state_ff == S_ACC) ? {cnt_new, sum_sat} : '0;

   // weight and read datapath
   assign freq_prod  = {1'b0, req_allele_freq[15:0], 1'b0} * (17'd65536 - req_allele_freq);
   assign radicand   = {freq_prod[31:0], 16'd0};
   assign sqrt_start = req_fire && (kind_type'(req_kind) == KIND_START) &&
                       (req_allele_freq != 17'd0) && !req_allele_freq[16];

   assign wnum = signed'({wx_ff, 16'd0}) - signed'({1'b0, freq_ff, 1'b0});
   assign wmag = wnum[17] ? 17'(-wnum) : wnum[16:0];

   assign sum_mag    = acc_sum[SumW-1] ? (SumW'(0) - acc_sum) : acc_sum;
   assign rd_divisor = {cnt_ff, 16'd0};

   always_comb begin
      div_start    = 1'b0;
      div_dividend = {23'd0, wmag, 24'd0} + DivW'(denom_ff >> 1);
      div_divisor  = {16'd0, denom_ff};
      if (state_ff == S_WLAUNCH) begin
         div_start = 1'b1;
      end else if ((state_ff == S_RD_WAIT) && (acc_cnt != '0)) begin
         div_start    = 1'b1;
         div_dividend = sum_mag;
         div_divisor  = {acc_cnt, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         sample_count_ff <= 13'(MaxSamples);
         pair_count_ff   <= '0;
         byte_pos_ff     <= '0;
         skip_ff         <= 1'b0;
         w_ff[0]         <= '0;
         w_ff[1]         <= '0;
         w_ff[2]         <= '0;
         wx_ff           <= '0;
         k_ff            <= '0;
         acc_valid_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_paddr[2] == REG_PAIR_COUNT) begin
               pair_count_ff <= csr_pwdata[SlotCntW-1:0];
            end else begin
               sample_count_ff <= csr_pwdata[12:0];
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (acc_wr_en) begin
            acc_valid_ff[acc_wr_addr] <= 1'b1;
         end
         if (acc_rd_en) begin
            acc_vld_ff <= acc_valid_ff[acc_rd_addr];
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (kind_type'(req_kind))
                     KIND_START: begin
                        byte_pos_ff <= '0;
                        freq_ff     <= req_allele_freq[15:0];
                        skip_ff     <= !sqrt_start;
                        if (sqrt_start) begin
                           state_ff <= S_SQRT;
                        end
                     end
                     KIND_BYTE: begin
                        if (row_end) begin
                           byte_pos_ff <= '0;
                           k_ff        <= '0;
                           if (!skip_ff && (pc_eff != '0)) begin
                              state_ff <= S_PAIR;
                           end
                        end else begin
                           byte_pos_ff <= pos_next[RowAddrW-1:0];
                        end
                     end
                     KIND_READ: begin
                        slot_ff  <= req_pair_index;
                        state_ff <= S_RD_WAIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  denom_ff <= sqrt_root;
                  wx_ff    <= '0;
                  state_ff <= S_WLAUNCH;
               end
            end
            S_WLAUNCH: begin
               state_ff <= S_WDIV;
            end
            S_WDIV: begin
               if (div_done) begin
                  unique case (wx_ff)
                     2'd0:    w_ff[0] <= wnum[17] ? -signed'(div_quot[WeightW-1:0])
                                                  : signed'(div_quot[WeightW-1:0]);
                     2'd1:    w_ff[1] <= wnum[17] ? -signed'(div_quot[WeightW-1:0])
                                                  : signed'(div_quot[WeightW-1:0]);
                     default: w_ff[2] <= wnum[17] ? -signed'(div_quot[WeightW-1:0])
                                                  : signed'(div_quot[WeightW-1:0]);
                  endcase
                  if (wx_ff == 2'd2) begin
                     state_ff <= S_IDLE;
                  end else begin
                     wx_ff    <= wx_ff + 2'd1;
                     state_ff <= S_WLAUNCH;
                  end
               end
            end
            S_PAIR: begin
               state_ff <= S_LO;
            end
            S_LO: begin
               lo_ff    <= pr_rd_data[MemberW-1:SampleW];
               hi_ff    <= pr_rd_data[SampleW-1:0];
               state_ff <= S_HI;
            end
            S_HI: begin
               ca_ff    <= miss_lo ? ALLELE_MISSING : geno_decode(row_rd_data, lo_ff[1:0]);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               pvalid_ff <= (ca_ff != ALLELE_MISSING) && (cb != ALLELE_MISSING);
               prod_ff   <= wa * wb;
               state_ff  <= S_ACC;
            end
            S_ACC: begin
               k_ff <= k_ff + SlotCntW'(1);
               if ((k_ff + SlotCntW'(1)) == pc_eff) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_PAIR;
               end
            end
            S_RD_WAIT: begin
               cnt_ff <= acc_cnt;
               neg_ff <= acc_sum[SumW-1];
               if (acc_cnt == '0) begin
                  rel_ff   <= '0;
                  state_ff <= S_RD_OUT;
               end else begin
                  state_ff <= S_RD_DIV;
               end
            end
            S_RD_DIV: begin
               if (div_done) begin
                  // round half away from zero on the magnitude
                  qr_ff    <= div_quot + DivW'({div_rem, 1'b0} >= {1'b0, rd_divisor});
                  state_ff <= S_RD_SAT;
               end
            end
            S_RD_SAT: begin
               if (neg_ff) begin
                  rel_ff <= (qr_ff > DivW'(8388608)) ? {1'b1, {(ResW-1){1'b0}}}
                                                     : -signed'(qr_ff[ResW-1:0]);
               end else begin
                  rel_ff <= (qr_ff > DivW'(8388607)) ? {1'b0, {(ResW-1){1'b1}}}
                                                     : signed'(qr_ff[ResW-1:0]);
               end
               state_ff <= S_RD_OUT;
            end
            S_RD_OUT: begin
               if (rsp_load) begin
                  rsp_slot_ff  <= slot_ff;
                  rsp_count_ff <= cnt_ff;
                  rsp_rel_ff   <= rel_ff;
                  rsp_def_ff   <= (cnt_ff != '0);
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pair_index_res = rsp_slot_ff;
   assign rsp_marker_count   = rsp_count_ff;
   assign rsp_relatedness    = rsp_rel_ff;
   assign rsp_defined        = rsp_def_ff;

   pgr_ram #(.WIDTH(MemberW), .DEPTH(MaxPairs)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pr_wr_en),
      .wr_addr (req_pair_index),
      .wr_data (pr_wr_data),
      .rd_en   (pr_rd_en),
      .rd_addr (k_ff[SlotW-1:0]),
      .rd_data (pr_rd_data)
   );

   pgr_ram #(.WIDTH(AccW), .DEPTH(MaxPairs)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   pgr_ram #(.WIDTH(8), .DEPTH(RowDepth)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (byte_pos_ff),
      .wr_data (req_geno_byte),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   pgr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   pgr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

endmodule

@@ sv/pgr_ram.sv @@
// pgr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module pgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pgr_sqrt.sv @@
// pgr_sqrt: bit-serial integer square root, one root bit per cycle
// depends on pgr_pkg
module pgr_sqrt
   import pgr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RadW-1:0]  radicand,
   output logic             done,
   output logic [RootW-1:0] root
);

   localparam int RemW = RootW + 3;

   logic [RadW-1:0]  rad_ff;
   logic [RemW-1:0]  rem_ff;
   logic [RootW-1:0] root_ff;
   logic [4:0]       step_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [RemW-1:0]  trial;
   logic [RemW-1:0]  test;
   logic             take;

   assign trial = {rem_ff[RemW-3:0], rad_ff[RadW-1:RadW-2]};
   assign test  = {1'b0, root_ff, 2'b01};
   assign take  = (trial >= test);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[RadW-3:0], 2'b00};
            rem_ff  <= take ? (trial - test) : trial;
            root_ff <= {root_ff[RootW-2:0], take};
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'(RootW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ sv/pgr_div.sv @@
// pgr_div: restoring divider, one quotient bit per cycle, shared by weights and reads
// depends on pgr_pkg
module pgr_div
   import pgr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DivW-1:0] dividend,
   input  logic [DvsW-1:0] divisor,
   output logic            done,
   output logic [DivW-1:0] quotient,
   output logic [DvsW-1:0] remainder
);

   logic [DivW-1:0] dq_ff;
   logic [DvsW-1:0] rem_ff;
   logic [DvsW-1:0] dvs_ff;
   logic [5:0]      step_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [DvsW:0]   trial;
   logic            take;

   assign trial = {rem_ff, dq_ff[DivW-1]};
   assign take  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dq_ff   <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= take ? DvsW'(trial - {1'b0, dvs_ff}) : trial[DvsW-1:0];
            dq_ff   <= {dq_ff[DivW-2:0], take};
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'(DivW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for pairwise_genomic_relatedness, req/rsp valid-ready
// with an apb-style csr port; depends on pgr_pkg and the block's rtl only
module testbench;
   import pgr_pkg::*;

   typedef struct packed {
      logic [SlotW-1:0]       slot;
      logic [CountW-1:0]      count;
      logic signed [ResW-1:0] rel;
      logic                   def;
   } pair_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = KIND_LOAD;
   logic [SlotW-1:0] req_pair_index = '0;
   logic [SampleW-1:0] req_first_sample = '0;
   logic [SampleW-1:0] req_second_sample = '0;
   logic [16:0] req_allele_freq = '0;
   logic [7:0] req_geno_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SlotW-1:0] rsp_pair_index_res;
   logic [CountW-1:0] rsp_marker_count;
   logic signed [ResW-1:0] rsp_relatedness;
   logic rsp_defined;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic [12:0] cfg_samples;
   logic [6:0] cfg_pairs;
   logic [SampleW-1:0] member_lo [MaxPairs];
   logic [SampleW-1:0] member_hi [MaxPairs];
   longint sum_of_products [MaxPairs];
   logic [CountW-1:0] markers_used [MaxPairs];
   logic [7:0] row_store [RowDepth];
   int weight [3];
   bit skip_marker;
   int row_pos;

   pair_result_type pending_results[$];
   int errors = 0;
   bit gaps_on = 1'b1;
   int rsp_hold = 0;

   always #4 clock = ~clock;

   pairwise_genomic_relatedness u_top (.*);

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic int eff_samples();
      if (cfg_samples == 0) return 1;
      if (cfg_samples > MaxSamples) return MaxSamples;
      return cfg_samples;
   endfunction

   // allele count of a sample in the stored row, 3 when missing
   function automatic int allele_of(int s, int n);
      logic [1:0] code;
      if (s >= n) return 3;
      code = 2'(row_store[s >> 2] >> ((s & 3) * 2));
      case (code)
         GENO_TWO: return 2;
         GENO_ONE: return 1;
         GENO_NONE: return 0;
         default: return 3;
      endcase
   endfunction

   task automatic set_weights(int p);
      longint unsigned v, d, mag, q;
      longint n;
      row_pos = 0;
      if (p == 0 || p >= 65536) begin
         skip_marker = 1'b1;
         return;
      end
      skip_marker = 1'b0;
      v = (64'd2 * p * (65536 - p)) << 16;
      d = int_sqrt(v);
      for (int x = 0; x < 3; x++) begin
         n = longint'(x) * 65536 - 2 * longint'(p);
         mag = (n < 0 ? -n : n) << 24;
         q = (mag + (d >> 1)) / d;
         weight[x] = n < 0 ? -int'(q) : int'(q);
      end
   endtask

   task automatic walk_pairs();
      int n, pc, a, b;
      longint prod, s;
      n = eff_samples();
      pc = cfg_pairs > MaxPairs ? MaxPairs : cfg_pairs;
      for (int k = 0; k < pc; k++) begin
         a = allele_of(member_lo[k], n);
         b = allele_of(member_hi[k], n);
         if (a > 2 || b > 2) continue;
         prod = longint'(weight[a]) * longint'(weight[b]);
         s = sum_of_products[k] + prod;
         if (prod > 0 && s < sum_of_products[k]) s = 64'h7fff_ffff_ffff_ffff;
         else if (prod < 0 && s > sum_of_products[k]) s = 64'h8000_0000_0000_0000;
         sum_of_products[k] = s;
         if (markers_used[k] != 24'hffffff) markers_used[k]++;
      end
   endtask

   task automatic predict_item(kind_type k, int slot, int a, int b, int p, int gbyte);
      pair_result_type r;
      longint unsigned mag, d, q, rem;
      bit neg;
      case (k)
         KIND_LOAD: begin
            member_lo[slot] = SampleW'(a < b ? a : b);
            member_hi[slot] = SampleW'(a < b ? b : a);
            sum_of_products[slot] = 0;
            markers_used[slot] = 0;
         end
         KIND_START: set_weights(p);
         KIND_BYTE: begin
            if (row_pos < RowDepth) row_store[row_pos] = 8'(gbyte);
            row_pos++;
            if (row_pos >= (eff_samples() + 3) / 4) begin
               row_pos = 0;
               if (!skip_marker) walk_pairs();
            end
         end
         default: begin
            r.slot = SlotW'(slot);
            r.count = markers_used[slot];
            r.def = markers_used[slot] != 0;
            r.rel = '0;
            if (r.def) begin
               neg = sum_of_products[slot] < 0;
               mag = neg ? -sum_of_products[slot] : sum_of_products[slot];
               d = longint'(markers_used[slot]) << 16;
               q = (mag >> 1) / (d >> 1);
               rem = mag - q * d;
               if (rem >= d - rem) q++;
               if (neg) r.rel = q > 8388608 ? -24'sd8388608 : ResW'(-q);
               else r.rel = q > 8388607 ? 24'sd8388607 : ResW'(q);
            end
            pending_results.push_back(r);
         end
      endcase
   endtask

   task automatic report(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      pair_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected result", rsp_pair_index_res, -1);
         end else begin
            e = pending_results.pop_front();
            if (rsp_pair_index_res !== e.slot) report("slot", rsp_pair_index_res, e.slot);
            if (rsp_marker_count !== e.count) report("count", rsp_marker_count, e.count);
            if (rsp_relatedness !== e.rel) report("relatedness", rsp_relatedness, e.rel);
            if (rsp_defined !== e.def) report("defined", rsp_defined, e.def);
         end
      end
   end

   // result side stalls, with long hold-offs at random and on request
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else if (!gaps_on) rsp_ready <= 1'b1;
      else if (r < 70) rsp_ready <= 1'b1;
      else if (r < 97) rsp_ready <= 1'b0;
      else begin
         rsp_ready <= 1'b0;
         rsp_hold = $urandom_range(10, 60);
      end
   end

   task automatic send_item(kind_type k, int slot = 0, int a = 0, int b = 0,
                            int p = 0, int gbyte = 0);
      int g, r;
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= k;
      req_pair_index <= SlotW'(slot);
      req_first_sample <= SampleW'(a);
      req_second_sample <= SampleW'(b);
      req_allele_freq <= 17'(p);
      req_geno_byte <= 8'(gbyte);
      do @(posedge clock); while (!req_ready);
      predict_item(k, slot, a, b, p, gbyte);
      r = $urandom_range(0, 99);
      g = !gaps_on || r < 60 ? 0 : r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic csr_write(logic regsel, int value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {regsel, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (regsel == REG_SAMPLE_COUNT) cfg_samples = 13'(value);
      else cfg_pairs = 7'(value);
   endtask

   // block goes idle: results drained, then room for a full pair walk
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   function automatic int rand_geno();
      int b;
      logic [1:0] c;
      b = 0;
      for (int l = 0; l < 4; l++) begin
         c = $urandom_range(0, 7) == 0 ? GENO_MISS : $urandom_range(0, 2) == 0 ? GENO_TWO :
             $urandom_range(0, 1) ? GENO_ONE : GENO_NONE;
         b |= c << (2 * l);
      end
      return b;
   endfunction

   task automatic full_row(int p);
      send_item(KIND_START, .p(p));
      repeat ((eff_samples() + 3) / 4) send_item(KIND_BYTE, .gbyte(rand_geno()));
   endtask

   task automatic test_directed();
      csr_write(REG_SAMPLE_COUNT, 8);
      csr_write(REG_PAIR_COUNT, 4);
      send_item(KIND_LOAD, 0, 5, 2);
      send_item(KIND_LOAD, 1, 0, 7);
      send_item(KIND_LOAD, 2, 3, 3);
      send_item(KIND_LOAD, 3, 0, 4095);
      send_item(KIND_READ, 0);
      // monomorphic markers, then both frequency extremes and the middle
      send_item(KIND_START, .p(0));
      send_item(KIND_BYTE, .gbyte(8'h00));
      send_item(KIND_BYTE, .gbyte(8'hff));
      send_item(KIND_START, .p(65536));
      send_item(KIND_BYTE, .gbyte(8'haa));
      send_item(KIND_BYTE, .gbyte(8'h55));
      send_item(KIND_START, .p(1));
      send_item(KIND_BYTE, .gbyte(8'h00));
      send_item(KIND_BYTE, .gbyte(8'hc3));
      send_item(KIND_START, .p(65535));
      send_item(KIND_BYTE, .gbyte(8'hff));
      send_item(KIND_BYTE, .gbyte(8'h3c));
      // restart in the middle of a row
      send_item(KIND_START, .p(32768));
      send_item(KIND_BYTE, .gbyte(8'h55));
      send_item(KIND_START, .p(12345));
      send_item(KIND_BYTE, .gbyte(8'h8e));
      send_item(KIND_BYTE, .gbyte(8'h2b));
      for (int s = 0; s < 4; s++) send_item(KIND_READ, s);
      // shrink the row while part way through it
      send_item(KIND_START, .p(40000));
      send_item(KIND_BYTE, .gbyte(8'h0a));
      drain();
      csr_write(REG_SAMPLE_COUNT, 0);
      send_item(KIND_BYTE, .gbyte(8'h02));
      send_item(KIND_READ, 2);
      drain();
   endtask

   task automatic test_random();
      int n_items, lim, sel;
      csr_write(REG_PAIR_COUNT, 0);
      for (int s = 0; s < MaxPairs; s++)
         send_item(KIND_LOAD, s, $urandom_range(0, 4095), $urandom_range(0, 4095));
      n_items = 0;
      while (n_items < 520) begin
         drain();
         sel = $urandom_range(0, 9);
         gaps_on = sel != 0;
         csr_write(REG_SAMPLE_COUNT, sel < 4 ? $urandom_range(1, 300) :
                   $urandom_range(1, 40));
         csr_write(REG_PAIR_COUNT, sel == 2 ? 127 : sel == 3 ? 64 : $urandom_range(0, 20));
         lim = eff_samples() + 2;
         repeat ($urandom_range(3, 8)) begin
            if (n_items < 520) begin
               sel = $urandom_range(0, 19);
               if (sel < 2) begin
                  send_item(KIND_LOAD, $urandom_range(0, 63), $urandom_range(0, lim),
                            sel == 0 ? $urandom_range(0, 4095) : $urandom_range(0, lim));
                  n_items++;
               end else if (sel == 2) begin
                  // broken row: restart before its end, unless the row is at most two bytes long
                  send_item(KIND_START, .p($urandom_range(0, 65536)));
                  repeat ($urandom_range(0, 2))
                     send_item(KIND_BYTE, .gbyte($urandom_range(0, 255)));
                  n_items += 2;
               end else begin
                  full_row(sel == 3 ? (sel & 1) * 65536 : $urandom_range(1, 65535));
                  n_items += 1 + (eff_samples() + 3) / 4;
               end
               repeat ($urandom_range(0, 3)) begin
                  send_item(KIND_READ, $urandom_range(0, 63));
                  n_items++;
               end
            end
         end
      end
      gaps_on = 1'b1;
      drain();
   endtask

   // receiver holds off while reads keep coming, stalling the input
   task automatic test_backpressure();
      rsp_hold = 600;
      for (int s = 0; s < 8; s++) send_item(KIND_READ, s);
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      cfg_samples = MaxSamples;
      cfg_pairs = 0;
      skip_marker = 1'b0;
      row_pos = 0;
      for (int x = 0; x < 3; x++) weight[x] = 0;
      for (int s = 0; s < MaxPairs; s++) begin
         sum_of_products[s] = 0;
         markers_used[s] = 0;
      end
      test_directed();
      test_random();
      test_backpressure();
      if (errors == 0) $display("PASS pairwise_genomic_relatedness");
      else $display("FAIL pairwise_genomic_relatedness");
      $finish;
   end

   initial begin
      #40ms;
      $display("FAIL pairwise_genomic_relatedness");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/pgr_pkg.sv
sv/pgr_ram.sv
sv/pgr_sqrt.sv
sv/pgr_div.sv
sv/pairwise_genomic_relatedness.sv
dv/testbench.sv
